### sv/thci_pkg.sv
// shared constants, codes and control types for the tag hash chain index
`timescale 1ns / 1ps

package thci_pkg;

    localparam int MAX_ENTRIES  = 1024;
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int KIND_W       = 2;
    localparam int TAG_PORT_W   = 16;
    localparam int TAG_BITS_DEF = 16;

    localparam logic [CNT_W-1:0] NONE_IDX  = '1;
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_ENTRIES);

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_BUILD = 2'd1,
        KIND_FIND  = 2'd2,
        KIND_NOP   = 2'd3
    } thci_kind_t;

    typedef struct packed {
        logic item_load;
        logic build_init;
        logic tag_wr;
        logic clr_wr;
        logic cnt_inc;
        logic cnt_dec;
        logic tag_rd_cnt;
        logic mod_start;
        logic mod_sel_find;
        logic head_rd;
        logic link_wr;
        logic build_set;
        logic done_set;
        logic next_rd_start;
        logic cur_load_head;
        logic cur_load_next;
        logic walk_rd;
        logic walk_adv;
        logic hit_set;
        logic out_load;
    } thci_cmd_t;

    typedef struct packed {
        thci_kind_t kind;
        logic       built;
        logic       start_neg;
        logic       start_oob;
        logic       cnt_last;
        logic       cnt_zero;
        logic       mod_done;
        logic       walk_end;
        logic       tag_hit;
    } thci_sts_t;

endpackage

### sv/thci_mod.sv
// iterative remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module thci_mod #(
    parameter int DIVIDEND_W = thci_pkg::TAG_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [DIVIDEND_W-1:0]       dividend,
    input  logic [thci_pkg::CNT_W-1:0]  divisor,
    output logic                        busy,
    output logic [thci_pkg::IDX_W-1:0]  remainder
);

    localparam int IDX_W  = thci_pkg::IDX_W;
    localparam int CNT_W  = thci_pkg::CNT_W;
    localparam int STEP_W = $clog2(DIVIDEND_W + 1);
    localparam logic [STEP_W-1:0] STEPS = STEP_W'(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]      div_reg, div_next;
    logic [IDX_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      rem_shift;
    logic [CNT_W-1:0]      rem_sub;

    assign rem_shift = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign rem_sub   = rem_shift - div_reg;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        quot_next = quot_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEPS;
            quot_next = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            quot_next = quot_reg << 1;
            step_next = step_reg - STEP_W'(1);
            if (rem_shift >= div_reg) begin
                rem_next = rem_sub[IDX_W-1:0];
            end else begin
                rem_next = rem_shift[IDX_W-1:0];
            end
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        step_reg <= step_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

### sv/thci_dp.sv
// datapath: tag, head and link memories, item and walk registers, result word
`timescale 1ns / 1ps

module thci_dp #(
    parameter int TAG_BITS = thci_pkg::TAG_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  thci_pkg::thci_cmd_t              cmd,
    output thci_pkg::thci_sts_t              sts,
    input  logic                             cfg_we,
    input  logic [thci_pkg::CNT_W-1:0]       cfg_data,
    input  logic [thci_pkg::KIND_W-1:0]      s_kind,
    input  logic [thci_pkg::IDX_W-1:0]       s_entry_index,
    input  logic [thci_pkg::TAG_PORT_W-1:0]  s_tag_value,
    input  logic signed [thci_pkg::CNT_W-1:0] s_start_index,
    output logic                             m_found,
    output logic [thci_pkg::IDX_W-1:0]       m_match_index,
    output logic                             m_done_res
);

    localparam int MAX_ENTRIES = thci_pkg::MAX_ENTRIES;
    localparam int IDX_W       = thci_pkg::IDX_W;
    localparam int CNT_W       = thci_pkg::CNT_W;

    // memories
    logic [TAG_BITS-1:0] entry_tags_reg  [MAX_ENTRIES];
    logic [CNT_W-1:0]    bucket_head_reg [MAX_ENTRIES];
    logic [CNT_W-1:0]    chain_next_reg  [MAX_ENTRIES];
    logic [TAG_BITS-1:0] tag_rdata_reg;
    logic [CNT_W-1:0]    head_rdata_reg;
    logic [CNT_W-1:0]    next_rdata_reg;

    thci_pkg::thci_kind_t kind_reg, kind_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic [CNT_W-1:0]     start_reg, start_next;
    logic [CNT_W-1:0]     entry_count_reg, entry_count_next;
    logic                 built_reg, built_next;
    logic [CNT_W-1:0]     built_count_reg, built_count_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     cur_reg, cur_next;
    logic [CNT_W-1:0]     step_reg, step_next;
    logic                 res_found_reg, res_found_next;
    logic [IDX_W-1:0]     res_match_reg, res_match_next;
    logic                 res_done_reg, res_done_next;
    logic                 out_found_reg, out_found_next;
    logic [IDX_W-1:0]     out_match_reg, out_match_next;
    logic                 out_done_reg, out_done_next;

    logic [31:0]          tag_wide;
    logic [TAG_BITS-1:0]  tag_in;
    logic [CNT_W-1:0]     eff_count;
    logic [TAG_BITS-1:0]  mod_dividend;
    logic                 mod_busy;
    logic [IDX_W-1:0]     mod_rem;

    logic                 tag_rd_en;
    logic [IDX_W-1:0]     tag_raddr;
    logic                 head_we;
    logic [IDX_W-1:0]     head_waddr;
    logic [CNT_W-1:0]     head_wdata;
    logic                 next_rd_en;
    logic [IDX_W-1:0]     next_raddr;

    assign tag_wide = {{(32 - thci_pkg::TAG_PORT_W){1'b0}}, s_tag_value};
    assign tag_in   = tag_wide[TAG_BITS-1:0];

    // entry count clamped to 1..MAX_ENTRIES
    always_comb begin
        if (entry_count_reg == '0) begin
            eff_count = thci_pkg::CNT_ONE;
        end else if (entry_count_reg > thci_pkg::CNT_MAX) begin
            eff_count = thci_pkg::CNT_MAX;
        end else begin
            eff_count = entry_count_reg;
        end
    end

    assign mod_dividend = cmd.mod_sel_find ? tag_reg : tag_rdata_reg;

    thci_mod #(
        .DIVIDEND_W (TAG_BITS)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (mod_dividend),
        .divisor   (built_count_reg),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    always_comb begin
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        tag_next         = tag_reg;
        start_next       = start_reg;
        entry_count_next = entry_count_reg;
        built_next       = built_reg;
        built_count_next = built_count_reg;
        cnt_next         = cnt_reg;
        cur_next         = cur_reg;
        step_next        = step_reg;
        res_found_next   = res_found_reg;
        res_match_next   = res_match_reg;
        res_done_next    = res_done_reg;
        out_found_next   = out_found_reg;
        out_match_next   = out_match_reg;
        out_done_next    = out_done_reg;
        if (cfg_we) begin
            entry_count_next = cfg_data;
            built_next       = 1'b0;
        end
        if (cmd.item_load) begin
            kind_next      = thci_pkg::thci_kind_t'(s_kind);
            idx_next       = s_entry_index;
            tag_next       = tag_in;
            start_next     = $unsigned(s_start_index);
            res_found_next = 1'b0;
            res_match_next = '0;
            res_done_next  = 1'b0;
        end
        if (cmd.build_init) begin
            built_count_next = eff_count;
            cnt_next         = '0;
        end
        if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.cnt_dec) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (cmd.build_set) begin
            built_next = 1'b1;
        end
        if (cmd.done_set) begin
            res_done_next = 1'b1;
        end
        if (cmd.cur_load_head) begin
            cur_next  = head_rdata_reg;
            step_next = '0;
        end
        if (cmd.cur_load_next) begin
            cur_next  = next_rdata_reg;
            step_next = '0;
        end
        if (cmd.walk_adv) begin
            cur_next  = next_rdata_reg;
            step_next = step_reg + CNT_W'(1);
        end
        if (cmd.hit_set) begin
            res_found_next = 1'b1;
            res_match_next = cur_reg[IDX_W-1:0];
        end
        if (cmd.out_load) begin
            out_found_next = res_found_reg;
            out_match_next = res_match_reg;
            out_done_next  = res_done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= thci_pkg::CNT_ONE;
            built_reg       <= 1'b0;
            built_count_reg <= thci_pkg::CNT_ONE;
        end else begin
            entry_count_reg <= entry_count_next;
            built_reg       <= built_next;
            built_count_reg <= built_count_next;
        end
        kind_reg      <= kind_next;
        idx_reg       <= idx_next;
        tag_reg       <= tag_next;
        start_reg     <= start_next;
        cnt_reg       <= cnt_next;
        cur_reg       <= cur_next;
        step_reg      <= step_next;
        res_found_reg <= res_found_next;
        res_match_reg <= res_match_next;
        res_done_reg  <= res_done_next;
        out_found_reg <= out_found_next;
        out_match_reg <= out_match_next;
        out_done_reg  <= out_done_next;
    end

    // tag memory
    assign tag_rd_en = cmd.tag_rd_cnt | cmd.walk_rd;
    assign tag_raddr = cmd.walk_rd ? cur_reg[IDX_W-1:0] : cnt_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.tag_wr) begin
            entry_tags_reg[idx_reg] <= tag_reg;
        end
        if (tag_rd_en) begin
            tag_rdata_reg <= entry_tags_reg[tag_raddr];
        end
    end

    // bucket head memory
    assign head_we    = cmd.clr_wr | cmd.link_wr;
    assign head_waddr = cmd.link_wr ? mod_rem : cnt_reg[IDX_W-1:0];
    assign head_wdata = cmd.link_wr ? cnt_reg : thci_pkg::NONE_IDX;

    always_ff @(posedge aclk) begin
        if (head_we) begin
            bucket_head_reg[head_waddr] <= head_wdata;
        end
        if (cmd.head_rd) begin
            head_rdata_reg <= bucket_head_reg[mod_rem];
        end
    end

    // chain link memory
    assign next_rd_en = cmd.next_rd_start | cmd.walk_rd;
    assign next_raddr = cmd.walk_rd ? cur_reg[IDX_W-1:0] : start_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.link_wr) begin
            chain_next_reg[cnt_reg[IDX_W-1:0]] <= head_rdata_reg;
        end
        if (next_rd_en) begin
            next_rdata_reg <= chain_next_reg[next_raddr];
        end
    end

    always_comb begin
        sts.kind      = kind_reg;
        sts.built     = built_reg;
        sts.start_neg = start_reg[CNT_W-1];
        sts.start_oob = {1'b0, start_reg[IDX_W-1:0]} >= built_count_reg;
        sts.cnt_last  = cnt_reg == (built_count_reg - CNT_W'(1));
        sts.cnt_zero  = cnt_reg == '0;
        sts.mod_done  = !mod_busy;
        sts.walk_end  = (cur_reg >= built_count_reg) || (step_reg > built_count_reg);
        sts.tag_hit   = tag_rdata_reg == tag_reg;
    end

    assign m_found       = out_found_reg;
    assign m_match_index = out_match_reg;
    assign m_done_res    = out_done_reg;

endmodule

### sv/thci_ctrl.sv
// controller state machine: sequences write, build and find items, and answers unused kinds directly
`timescale 1ns / 1ps

module thci_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  thci_pkg::thci_sts_t sts,
    output thci_pkg::thci_cmd_t cmd
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_DISPATCH = 15'b000000000000010,
        S_WRITE    = 15'b000000000000100,
        S_CLEAR    = 15'b000000000001000,
        S_BRD      = 15'b000000000010000,
        S_BMODST   = 15'b000000000100000,
        S_BMOD     = 15'b000000001000000,
        S_BLINK    = 15'b000000010000000,
        S_FSTART   = 15'b000000100000000,
        S_FMOD     = 15'b000001000000000,
        S_FLOADH   = 15'b000010000000000,
        S_FLOADN   = 15'b000100000000000,
        S_FCHK     = 15'b001000000000000,
        S_FCMP     = 15'b010000000000000,
        S_RESP     = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (sts.kind)
                    thci_pkg::KIND_WRITE: state_next = S_WRITE;
                    thci_pkg::KIND_BUILD: begin
                        cmd.build_init = 1'b1;
                        state_next     = S_CLEAR;
                    end
                    thci_pkg::KIND_FIND: state_next = S_FSTART;
                    default: state_next = S_RESP;
                endcase
            end
            S_WRITE: begin
                cmd.tag_wr   = 1'b1;
                cmd.done_set = 1'b1;
                state_next   = S_RESP;
            end
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.cnt_last) begin
                    state_next = S_BRD;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_BRD: begin
                cmd.tag_rd_cnt = 1'b1;
                state_next     = S_BMODST;
            end
            S_BMODST: begin
                cmd.mod_start = 1'b1;
                state_next    = S_BMOD;
            end
            S_BMOD: begin
                if (sts.mod_done) begin
                    cmd.head_rd = 1'b1;
                    state_next  = S_BLINK;
                end
            end
            S_BLINK: begin
                cmd.link_wr = 1'b1;
                if (sts.cnt_zero) begin
                    cmd.build_set = 1'b1;
                    cmd.done_set  = 1'b1;
                    state_next    = S_RESP;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_BRD;
                end
            end
            S_FSTART: begin
                if (!sts.built) begin
                    state_next = S_RESP;
                end else if (sts.start_neg) begin
                    cmd.mod_start    = 1'b1;
                    cmd.mod_sel_find = 1'b1;
                    state_next       = S_FMOD;
                end else if (sts.start_oob) begin
                    state_next = S_RESP;
                end else begin
                    cmd.next_rd_start = 1'b1;
                    state_next        = S_FLOADN;
                end
            end
            S_FMOD: begin
                if (sts.mod_done) begin
                    cmd.head_rd = 1'b1;
                    state_next  = S_FLOADH;
                end
            end
            S_FLOADH: begin
                cmd.cur_load_head = 1'b1;
                state_next        = S_FCHK;
            end
            S_FLOADN: begin
                cmd.cur_load_next = 1'b1;
                state_next        = S_FCHK;
            end
            S_FCHK: begin
                if (sts.walk_end) begin
                    state_next = S_RESP;
                end else begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_FCMP;
                end
            end
            S_FCMP: begin
                if (sts.tag_hit) begin
                    cmd.hit_set = 1'b1;
                    state_next  = S_RESP;
                end else begin
                    cmd.walk_adv = 1'b1;
                    state_next   = S_FCHK;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

endmodule

### sv/tag_hash_chain_index.sv
// a write, an unused kind, and a find before build or past the count go straight to the result
// find: walks the chain from the bucket head, or from the link after a start index, one entry compared per step
// build of n entries: the bit-serial remainder of each entry's tag picks its bucket
// one word at a time: the next word is taken the cycle after a result loads
// reset: synchronous active low, clears state machine, output valid, entry count to 1 and build flag
`timescale 1ns / 1ps

module tag_hash_chain_index #(
    parameter int TAG_BITS = thci_pkg::TAG_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [thci_pkg::CNT_W-1:0]         cfg_entry_count,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [thci_pkg::KIND_W-1:0]        s_kind,
    input  logic [thci_pkg::IDX_W-1:0]         s_entry_index,
    input  logic [thci_pkg::TAG_PORT_W-1:0]    s_tag_value,
    input  logic signed [thci_pkg::CNT_W-1:0]  s_start_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_found,
    output logic [thci_pkg::IDX_W-1:0]         m_match_index,
    output logic                               m_done_res
);

    thci_pkg::thci_cmd_t cmd;
    thci_pkg::thci_sts_t sts;

    assign cfg_ready = 1'b1;

    thci_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    thci_dp #(
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_data      (cfg_entry_count),
        .s_kind        (s_kind),
        .s_entry_index (s_entry_index),
        .s_tag_value   (s_tag_value),
        .s_start_index (s_start_index),
        .m_found       (m_found),
        .m_match_index (m_match_index),
        .m_done_res    (m_done_res)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("word taken while another is in progress");

    a_found_xor_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_done_res))
        else $error("result marks both a match and a completion");

    a_miss_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_match_index == '0)
        else $error("nonzero match index without a match");
`endif

endmodule
